// ===== sv/gto_pkg.sv =====
package gto_pkg;

	// Item kinds after decode of the mode field
	typedef enum logic [1:0] {
		KIND_POINT  = 2'd0,
		KIND_START  = 2'd1,
		KIND_STOP   = 2'd2,
		KIND_IGNORE = 2'd3
	} kind_t;

	// Raw mode codes on the input stream
	localparam logic [1:0] MODE_POINT = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_STOP  = 2'd2;

	// Register indexes on the configuration port
	localparam logic REG_CLIMB  = 1'b0;
	localparam logic REG_RADIUS = 1'b1;

	localparam logic [9:0]  CLIMB_RESET  = 10'd50;
	localparam logic [22:0] RADIUS_RESET = 23'd6371000;

	localparam logic signed [30:0] LAT_LIMIT = 31'sd900000000;
	localparam logic [31:0] HALF_TURN    = 32'd3600000000;
	localparam logic [31:0] QUARTER_TURN = 32'd1800000000;
	// pi * 2^30 / 2 over half turn / 2: radians in Q30 = u * RAD_NUM / RAD_DEN
	localparam logic [31:0] RAD_NUM = 32'd1686629713;
	localparam logic [31:0] RAD_DEN = 32'd1800000000;
	// RAD_NUM / RAD_DEN in Q32, rounded down: the estimate is low by at most one
	localparam logic [31:0] RAD_RECIP = 32'((64'(RAD_NUM) << 32) / 64'(RAD_DEN));
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [30:0] Q30_ONE = 31'd1073741824;
	localparam logic [30:0] STEP_MAX = 31'h7FFFFFFF;

	localparam int QDEPTH = 4;

	typedef struct packed {
		kind_t              kind;
		logic signed [30:0] lat;
		logic signed [31:0] lon;
		logic signed [20:0] alt;
	} item_t;

	typedef struct packed {
		logic        recording;
		logic [39:0] distance;
		logic [31:0] ascent;
		logic [31:0] descent;
		logic [31:0] points;
		logic [30:0] step;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_RMUL, S_RDIV, S_RFIX, S_ROT, S_A0, S_A1, S_A2, S_A3,
		S_SQI, S_SQ, S_VEC, S_DMUL, S_FIN, S_OUT
	} phase_t;

	// Arctangent of 2^-i in Q30
	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] v;
		begin
			unique case (i)
				5'd0:  v = 32'h3243F6A8;
				5'd1:  v = 32'h1DAC6705;
				5'd2:  v = 32'h0FADBAFC;
				5'd3:  v = 32'h07F56EA6;
				5'd4:  v = 32'h03FEAB76;
				5'd5:  v = 32'h01FFD55B;
				5'd6:  v = 32'h00FFFAAA;
				5'd7:  v = 32'h007FFF55;
				5'd8:  v = 32'h003FFFEA;
				5'd9:  v = 32'h001FFFFD;
				5'd10: v = 32'h000FFFFF;
				5'd11: v = 32'h0007FFFF;
				5'd12: v = 32'h0003FFFF;
				5'd13: v = 32'h0001FFFF;
				5'd14: v = 32'h0000FFFF;
				5'd15: v = 32'h00007FFF;
				5'd16: v = 32'h00003FFF;
				5'd17: v = 32'h00001FFF;
				5'd18: v = 32'h00000FFF;
				5'd19: v = 32'h000007FF;
				5'd20: v = 32'h000003FF;
				5'd21: v = 32'h000001FF;
				5'd22: v = 32'h000000FF;
				5'd23: v = 32'h0000007F;
				5'd24: v = 32'h0000003F;
				5'd25: v = 32'h0000001F;
				5'd26: v = 32'h0000000F;
				5'd27: v = 32'h00000008;
				5'd28: v = 32'h00000004;
				5'd29: v = 32'h00000002;
				5'd30: v = 32'h00000001;
				default: v = 32'h00000000;
			endcase
			return v;
		end
	endfunction

	// Reduce an angle magnitude (5e-8 degree units) mod 180 deg, mirror about 90
	function automatic logic [30:0] fold_angle(input logic [31:0] h);
		logic [31:0] m;
		begin
			m = (h >= HALF_TURN) ? h - HALF_TURN : h;
			if (m > QUARTER_TURN)
				m = HALF_TURN - m;
			return m[30:0];
		end
	endfunction

	// Clamp a CORDIC output to [0, 1.0] in Q30
	function automatic logic [30:0] clamp_unit(input logic signed [33:0] v);
		logic [30:0] r;
		begin
			if (v < 0)
				r = '0;
			else if (v > $signed({3'b000, Q30_ONE}))
				r = Q30_ONE;
			else
				r = v[30:0];
			return r;
		end
	endfunction

endpackage

// ===== sv/gto_front.sv =====
module gto_front
	import gto_pkg::*;
(
	input  logic [87:0] tdata,
	input  logic [1:0]  tuser,
	output item_t       item
);

	logic signed [30:0] lat_raw;

	assign lat_raw = tdata[30:0];

	// Classify the mode code
	always_comb begin
		unique case (tuser)
			MODE_POINT: item.kind = KIND_POINT;
			MODE_START: item.kind = KIND_START;
			MODE_STOP:  item.kind = KIND_STOP;
			default:    item.kind = KIND_IGNORE;
		endcase
	end

	// Saturate latitude at the poles
	always_comb begin
		if (lat_raw > LAT_LIMIT)
			item.lat = LAT_LIMIT;
		else if (lat_raw < -LAT_LIMIT)
			item.lat = -LAT_LIMIT;
		else
			item.lat = lat_raw;
	end

	assign item.lon = tdata[62:31];
	assign item.alt = tdata[83:63];

endmodule

// ===== sv/gto_queue.sv =====
module gto_queue
	import gto_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_data,
	output logic  pop_valid,
	input  logic  pop,
	output item_t pop_data
);

	localparam int AW = $clog2(QDEPTH);

	item_t          mem_q [QDEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [AW:0]    count_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (count_q != (AW+1)'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Store incoming requests
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== sv/gto_back.sv =====
module gto_back
	import gto_pkg::*;
#(
	parameter int CORDIC_STEPS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [9:0]  climb_thr,
	input  logic [22:0] radius,
	input  logic        q_valid,
	input  item_t       q_data,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     out_data
);

	localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

	phase_t state_q, state_d;

	// Architectural state
	logic               rec_q;
	logic               have_prev_q;
	logic signed [30:0] prev_lat_q;
	logic signed [31:0] prev_lon_q;
	logic signed [20:0] prev_alt_q;
	logic [39:0]        dist_q;
	logic [31:0]        ascent_q;
	logic [31:0]        descent_q;
	logic [31:0]        points_q;

	// Working registers
	item_t              item_q;
	logic [30:0]        u_q [4];
	logic [1:0]         ang_q;
	logic [4:0]         cnt_q;
	logic [30:0]        qest_q;
	logic [61:0]        qden_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic [30:0]        sl_q, sn_q, c1_q, c2_q;
	logic [30:0]        t_q, w_q, a_q;
	logic [63:0]        srem0_q, sres0_q, srem1_q, sres1_q, sbit_q;
	logic [30:0]        ang_z_q;
	logic [29:0]        r100_q;
	logic [30:0]        step_q;
	logic               out_valid_q;
	result_t            out_q;

	// Shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;

	always_comb begin
		unique case (state_q)
			S_RMUL: begin mul_a = {1'b0, u_q[ang_q]}; mul_b = RAD_RECIP; end
			S_RDIV: begin mul_a = {1'b0, qest_q}; mul_b = RAD_DEN; end
			S_RFIX: begin mul_a = {1'b0, u_q[ang_q]}; mul_b = RAD_NUM; end
			S_A0:   begin mul_a = {1'b0, c1_q}; mul_b = {1'b0, c2_q}; end
			S_A1:   begin mul_a = {1'b0, sn_q}; mul_b = {1'b0, sn_q}; end
			S_A2:   begin mul_a = {1'b0, t_q};  mul_b = {1'b0, w_q}; end
			S_A3:   begin mul_a = {1'b0, sl_q}; mul_b = {1'b0, sl_q}; end
			S_DMUL: begin mul_a = {2'b00, r100_q}; mul_b = {ang_z_q, 1'b0}; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign prod = mul_a * mul_b;

	// Front-end differences for the distance path
	logic signed [31:0] dlat;
	logic signed [32:0] dlon;
	logic [31:0]        adlat, adlon;
	logic [30:0]        alat1, alat2;

	assign dlat  = {item_q.lat[30], item_q.lat} - {prev_lat_q[30], prev_lat_q};
	assign dlon  = {item_q.lon[31], item_q.lon} - {prev_lon_q[31], prev_lon_q};
	assign adlat = dlat[31] ? 32'(-dlat) : 32'(dlat);
	assign adlon = dlon[32] ? 32'(-dlon) : 32'(dlon);
	assign alat1 = prev_lat_q[30] ? 31'(-prev_lat_q) : 31'(prev_lat_q);
	assign alat2 = item_q.lat[30] ? 31'(-item_q.lat) : 31'(item_q.lat);

	// Radian conversion: reciprocal estimate, then one correction step
	logic [63:0] rad_rem;
	logic        rad_bump;
	logic [30:0] rad_q30;

	assign rad_rem  = prod - {2'b00, qden_q};
	assign rad_bump = (rad_rem >= {32'd0, RAD_DEN});
	assign rad_q30  = rad_bump ? qest_q + 31'd1 : qest_q;

	// CORDIC step, shared by rotation and vectoring
	logic               sigma;
	logic signed [33:0] xs, ys, at, x_n, y_n, z_n;

	assign sigma = (state_q == S_ROT) ? (z_q >= 0) : !(y_q > 0);
	assign xs    = x_q >>> cnt_q;
	assign ys    = y_q >>> cnt_q;
	assign at    = $signed({2'b00, atan_q30(cnt_q)});
	assign x_n   = sigma ? x_q - ys : x_q + ys;
	assign y_n   = sigma ? y_q + xs : y_q - xs;
	assign z_n   = sigma ? z_q - at : z_q + at;

	// Square root steps, both roots side by side
	logic [63:0] st0, st1;
	assign st0 = sres0_q + sbit_q;
	assign st1 = sres1_q + sbit_q;

	// Haversine term and distance scaling
	logic [31:0] a_sum;
	logic [62:0] d_sum;
	logic [32:0] d_cm;

	assign a_sum = {1'b0, prod[60:30]} + {1'b0, t_q};
	assign d_sum = {1'b0, prod[61:0]} + 63'h20000000;
	assign d_cm  = d_sum[62:30];

	// Point updates
	logic signed [21:0] dalt;
	logic signed [21:0] thr_s;
	logic [40:0]        dist_sum;
	logic [32:0]        asc_sum, desc_sum;
	logic [21:0]        dalt_neg;

	assign dalt     = {item_q.alt[20], item_q.alt} - {prev_alt_q[20], prev_alt_q};
	assign thr_s    = $signed({12'd0, climb_thr});
	assign dalt_neg = 22'(-dalt);
	assign dist_sum = {1'b0, dist_q} + {10'd0, step_q};
	assign asc_sum  = {1'b0, ascent_q} + {11'd0, dalt};
	assign desc_sum = {1'b0, descent_q} + {11'd0, dalt_neg};

	// Hold state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// Sequence one request at a time
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (item_q.kind == KIND_POINT && rec_q)
					state_d = have_prev_q ? S_RMUL : S_FIN;
				else
					state_d = S_OUT;
			end
			S_RMUL: state_d = S_RDIV;
			S_RDIV: state_d = S_RFIX;
			S_RFIX: state_d = S_ROT;
			S_ROT: begin
				if (cnt_q == LAST_STEP)
					state_d = (ang_q == 2'd3) ? S_A0 : S_RMUL;
			end
			S_A0:   state_d = S_A1;
			S_A1:   state_d = S_A2;
			S_A2:   state_d = S_A3;
			S_A3:   state_d = S_SQI;
			S_SQI:  state_d = S_SQ;
			S_SQ:   if (cnt_q == 5'd31) state_d = S_VEC;
			S_VEC:  if (cnt_q == LAST_STEP) state_d = S_DMUL;
			S_DMUL: state_d = S_FIN;
			S_FIN:  state_d = S_OUT;
			S_OUT:  if (!out_valid_q || out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (q_valid)
					item_q <= q_data;
			end
			S_EXEC: begin
				step_q <= '0;
				r100_q <= 30'(radius) * 30'd100;
				ang_q  <= '0;
				u_q[0] <= fold_angle(adlat);
				u_q[1] <= fold_angle(adlon);
				u_q[2] <= fold_angle({alat1, 1'b0});
				u_q[3] <= fold_angle({alat2, 1'b0});
			end
			S_RMUL: qest_q <= prod[62:32];
			S_RDIV: qden_q <= prod[61:0];
			S_RFIX: begin
				x_q   <= CORDIC_GAIN;
				y_q   <= '0;
				z_q   <= $signed({3'b000, rad_q30});
				cnt_q <= '0;
			end
			S_ROT: begin
				x_q   <= x_n;
				y_q   <= y_n;
				z_q   <= z_n;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					ang_q <= ang_q + 1'b1;
					case (ang_q)
						2'd0: sl_q <= clamp_unit(y_n);
						2'd1: sn_q <= clamp_unit(y_n);
						2'd2: c1_q <= clamp_unit(x_n);
						default: c2_q <= clamp_unit(x_n);
					endcase
				end
			end
			S_A0: t_q <= prod[60:30];
			S_A1: w_q <= prod[60:30];
			S_A2: t_q <= prod[60:30];
			S_A3: a_q <= (a_sum > {1'b0, Q30_ONE}) ? Q30_ONE : a_sum[30:0];
			S_SQI: begin
				srem0_q <= {3'd0, a_q, 30'd0};
				srem1_q <= {3'd0, 31'(Q30_ONE - a_q), 30'd0};
				sres0_q <= '0;
				sres1_q <= '0;
				sbit_q  <= 64'h4000000000000000;
				cnt_q   <= '0;
			end
			S_SQ: begin
				if (srem0_q >= st0) begin
					srem0_q <= srem0_q - st0;
					sres0_q <= (sres0_q >> 1) + sbit_q;
				end else begin
					sres0_q <= sres0_q >> 1;
				end
				if (srem1_q >= st1) begin
					srem1_q <= srem1_q - st1;
					sres1_q <= (sres1_q >> 1) + sbit_q;
				end else begin
					sres1_q <= sres1_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q == 5'd31) begin
					// Both roots are final after this step
					x_q   <= (srem1_q >= st1) ? 34'((sres1_q >> 1) + sbit_q)
						: 34'(sres1_q >> 1);
					y_q   <= (srem0_q >= st0) ? 34'((sres0_q >> 1) + sbit_q)
						: 34'(sres0_q >> 1);
					z_q   <= '0;
					cnt_q <= '0;
				end
			end
			S_VEC: begin
				x_q   <= x_n;
				y_q   <= y_n;
				z_q   <= z_n;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					if (z_n < 0)
						ang_z_q <= '0;
					else if (z_n > $signed({3'b000, HALF_PI_Q30}))
						ang_z_q <= HALF_PI_Q30;
					else
						ang_z_q <= z_n[30:0];
				end
			end
			S_DMUL: step_q <= (d_cm > {2'b00, STEP_MAX}) ? STEP_MAX : d_cm[30:0];
			default: ;
		endcase
	end

	// Statistics and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q       <= 1'b0;
			have_prev_q <= 1'b0;
			prev_lat_q  <= '0;
			prev_lon_q  <= '0;
			prev_alt_q  <= '0;
			dist_q      <= '0;
			ascent_q    <= '0;
			descent_q   <= '0;
			points_q    <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (state_q == S_OUT && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_EXEC: begin
					case (item_q.kind)
						KIND_START: begin
							if (!rec_q) begin
								rec_q       <= 1'b1;
								have_prev_q <= 1'b0;
								dist_q      <= '0;
								ascent_q    <= '0;
								descent_q   <= '0;
								points_q    <= '0;
							end
						end
						KIND_STOP: rec_q <= 1'b0;
						default: ;
					endcase
				end
				S_FIN: begin
					if (points_q != 32'hFFFFFFFF)
						points_q <= points_q + 1'b1;
					if (have_prev_q) begin
						dist_q <= dist_sum[40] ? 40'hFFFFFFFFFF : dist_sum[39:0];
						if (dalt > thr_s)
							ascent_q <= asc_sum[32] ? 32'hFFFFFFFF : asc_sum[31:0];
						else if (dalt < -thr_s)
							descent_q <= desc_sum[32] ? 32'hFFFFFFFF : desc_sum[31:0];
					end
					prev_lat_q  <= item_q.lat;
					prev_lon_q  <= item_q.lon;
					prev_alt_q  <= item_q.alt;
					have_prev_q <= 1'b1;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_q.recording <= rec_q;
						out_q.distance  <= dist_q;
						out_q.ascent    <= ascent_q;
						out_q.descent   <= descent_q;
						out_q.points    <= points_q;
						out_q.step      <= step_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== sv/gps_track_odometer_top.sv =====
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tdata: latitude, longitude, altitude_cm; tuser: mode
// m_*       out  m_tvalid/m_tready    tdata: distance, ascent, descent, points, step; tuser: recording
// apb       in   psel/penable/pready  0x0 climb_threshold_cm, 0x4 earth_radius_m
//
// Commands and ignored points go from the queue through the execute and output states to the result register.
// A point with a previous fix also passes through the shared CORDIC unit, a
// three-multiply radian conversion per angle, and the 32-step square roots.
// Reset is asynchronous and clears all totals. A four-entry request queue keeps
// accepting, until full, while the back end works or the result register waits
// on m_tready.
module gps_track_odometer_top
	import gto_pkg::*;
#(
	parameter int CORDIC_STEPS = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [87:0]  s_tdata,   // latitude[30:0], longitude[62:31], altitude_cm[83:63]
	input  logic [1:0]   s_tuser,   // mode[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [167:0] m_tdata,   // distance[39:0], ascent[71:40], descent[103:72],
	                                // point_total[135:104], step_distance[166:136]
	output logic [0:0]   m_tuser,   // recording[0]
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [9:0]  climb_q;
	logic [22:0] radius_q;
	item_t       front_item;
	item_t       q_data;
	logic        q_valid;
	logic        q_pop;
	result_t     res;

	assign pready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			climb_q  <= CLIMB_RESET;
			radius_q <= RADIUS_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_CLIMB:  climb_q  <= pwdata[9:0];
				REG_RADIUS: radius_q <= pwdata[22:0];
				default: ;
			endcase
		end
	end

	// Read back configuration
	always_comb begin
		unique case (paddr[2])
			REG_CLIMB:  prdata = {22'd0, climb_q};
			REG_RADIUS: prdata = {9'd0, radius_q};
			default:    prdata = '0;
		endcase
	end

	gto_front u_front (
		.tdata (s_tdata),
		.tuser (s_tuser),
		.item  (front_item)
	);

	gto_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (s_tvalid),
		.push_ready (s_tready),
		.push_data  (front_item),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_data   (q_data)
	);

	gto_back #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.climb_thr (climb_q),
		.radius    (radius_q),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res)
	);

	// Pack result stream
	assign m_tdata = {1'b0, res.step, res.points, res.descent, res.ascent, res.distance};
	assign m_tuser = res.recording;

endmodule

// ===== sim/gto_checker.sv =====
`timescale 1ns / 100ps

module gto_checker
	import gto_pkg::*;
(
	input  logic         clk,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [87:0]  s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [167:0] m_tdata,
	input  logic [0:0]   m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           mismatch_count,
	output int           results_pending
);

	localparam longint unsigned ONE_Q30   = 64'd1073741824;
	localparam longint          GAIN_Q30  = 64'sd652032874;
	localparam longint          RIGHT_Q30 = 64'sd1686629713;
	localparam longint unsigned PI_Q30    = 64'd3373259426;
	localparam longint unsigned HALF_REV  = 64'd3600000000;
	localparam longint unsigned QTR_REV   = 64'd1800000000;
	localparam longint          POLE      = 64'sd900000000;
	localparam longint unsigned MAX40     = 64'hFF_FFFF_FFFF;
	localparam longint unsigned MAX32     = 64'hFFFF_FFFF;
	localparam longint unsigned MAX31     = 64'h7FFF_FFFF;
	localparam int              ROT_STEPS = 24;

	longint arctan_tab [32] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
		64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
		64'h00000001, 64'h00000000
	};

	// Shadow registers and track state
	longint unsigned climb_thr, radius_m;
	logic            rec_on, have_fix;
	longint          last_lat, last_lon, last_alt;
	longint unsigned sum_dist, sum_up, sum_down, fix_count;

	result_t odo_expected [$];

	function automatic longint unsigned fold_half(input longint unsigned h);
		longint unsigned m;
		m = h % HALF_REV;
		if (m > QTR_REV)
			m = HALF_REV - m;
		return m;
	endfunction

	function automatic longint clamp_q30(input longint v);
		if (v < 0)
			return 0;
		if (v > longint'(ONE_Q30))
			return longint'(ONE_Q30);
		return v;
	endfunction

	// Rotation CORDIC: cosine and sine of an angle in 5e-8 degree units
	task automatic sin_cos(input longint unsigned u, output longint c, output longint s);
		longint x, y, z, dx, dy;
		x = GAIN_Q30;
		y = 0;
		z = longint'(u * PI_Q30 / HALF_REV);
		for (int i = 0; i < ROT_STEPS; i++) begin
			dx = y >>> (i & 31);
			dy = x >>> (i & 31);
			if (z >= 0) begin
				x -= dx; y += dy; z -= arctan_tab[i & 31];
			end else begin
				x += dx; y -= dy; z += arctan_tab[i & 31];
			end
		end
		c = clamp_q30(x);
		s = clamp_q30(y);
	endtask

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned rem, res, b;
		rem = v;
		res = 0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + b) begin
				rem -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Vectoring CORDIC: half the central angle in Q30
	function automatic longint arc_angle(input longint y_in, input longint x_in);
		longint x, y, z, dx, dy;
		x = x_in;
		y = y_in;
		z = 0;
		for (int i = 0; i < ROT_STEPS; i++) begin
			dx = y >>> (i & 31);
			dy = x >>> (i & 31);
			if (y > 0) begin
				x += dx; y -= dy; z += arctan_tab[i & 31];
			end else begin
				x -= dx; y += dy; z -= arctan_tab[i & 31];
			end
		end
		if (z < 0)
			z = 0;
		if (z > RIGHT_Q30)
			z = RIGHT_Q30;
		return z;
	endfunction

	// Haversine leg length in cm
	task automatic leg_cm(input longint lat1, input longint lon1, input longint lat2,
			input longint lon2, output longint unsigned leg_len);
		longint dlat, dlon, cl, sl, cn, sn, c1, s1, c2, s2, z;
		longint unsigned term, hav, ra, rb;
		dlat = lat2 - lat1;
		dlon = lon2 - lon1;
		sin_cos(fold_half(dlat < 0 ? -dlat : dlat), cl, sl);
		sin_cos(fold_half(dlon < 0 ? -dlon : dlon), cn, sn);
		sin_cos(fold_half(2 * (lat1 < 0 ? -lat1 : lat1)), c1, s1);
		sin_cos(fold_half(2 * (lat2 < 0 ? -lat2 : lat2)), c2, s2);
		term = (longint'(c1) * longint'(c2)) >> 30;
		term = (term * ((longint'(sn) * longint'(sn)) >> 30)) >> 30;
		hav = ((longint'(sl) * longint'(sl)) >> 30) + term;
		if (hav > ONE_Q30)
			hav = ONE_Q30;
		ra = int_sqrt(hav << 30);
		rb = int_sqrt((ONE_Q30 - hav) << 30);
		z = arc_angle(longint'(ra), longint'(rb));
		leg_len = (radius_m * 100 * (2 * longint'(z)) + (64'd1 << 29)) >> 30;
		if (leg_len > MAX31)
			leg_len = MAX31;
	endtask

	// Advance the track state for one request and queue the expected result
	task automatic track_request(input logic [1:0] mode_in, input logic [87:0] data);
		longint          lat, lon, alt, dalt;
		longint unsigned step;
		result_t         r;
		step = 0;
		case (kind_t'(mode_in))
			KIND_START: begin
				if (!rec_on) begin
					rec_on = 1'b1;
					have_fix = 1'b0;
					sum_dist = 0; sum_up = 0; sum_down = 0; fix_count = 0;
				end
			end
			KIND_STOP: rec_on = 1'b0;
			KIND_POINT: begin
				if (rec_on) begin
					lat = $signed(data[30:0]);
					lon = $signed(data[62:31]);
					alt = $signed(data[83:63]);
					if (lat > POLE)
						lat = POLE;
					if (lat < -POLE)
						lat = -POLE;
					if (fix_count < MAX32)
						fix_count++;
					if (have_fix) begin
						dalt = alt - last_alt;
						leg_cm(last_lat, last_lon, lat, lon, step);
						sum_dist = (sum_dist + step > MAX40) ? MAX40 : sum_dist + step;
						if (dalt > longint'(climb_thr))
							sum_up = (sum_up + dalt > MAX32) ? MAX32 : sum_up + dalt;
						else if (dalt < -longint'(climb_thr))
							sum_down = (sum_down - dalt > MAX32) ? MAX32 : sum_down - dalt;
					end
					last_lat = lat;
					last_lon = lon;
					last_alt = alt;
					have_fix = 1'b1;
				end
			end
			default: ;
		endcase
		r.recording = rec_on;
		r.distance  = sum_dist[39:0];
		r.ascent    = sum_up[31:0];
		r.descent   = sum_down[31:0];
		r.points    = fix_count[31:0];
		r.step      = step[30:0];
		odo_expected.push_back(r);
	endtask

	initial begin
		climb_thr = CLIMB_RESET;
		radius_m = RADIUS_RESET;
		rec_on = 1'b0;
		have_fix = 1'b0;
		last_lat = 0; last_lon = 0; last_alt = 0;
		sum_dist = 0; sum_up = 0; sum_down = 0; fix_count = 0;
		mismatch_count = 0;
	end

	assign results_pending = odo_expected.size();

	// Track register writes, requests and results
	always @(posedge clk) begin
		result_t want, got;
		if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_CLIMB)
				climb_thr = pwdata[9:0];
			else if (paddr[2] == REG_RADIUS)
				radius_m = pwdata[22:0];
		end
		if (s_tvalid && s_tready)
			track_request(s_tuser, s_tdata);
		if (m_tvalid && m_tready) begin
			got.recording = m_tuser[0];
			got.distance  = m_tdata[39:0];
			got.ascent    = m_tdata[71:40];
			got.descent   = m_tdata[103:72];
			got.points    = m_tdata[135:104];
			got.step      = m_tdata[166:136];
			if (odo_expected.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result %h", got);
			end else begin
				want = odo_expected.pop_front();
				if (want != got) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch rec %b/%b dist %0d/%0d up %0d/%0d down %0d/%0d pts %0d/%0d step %0d/%0d",
							want.recording, got.recording, want.distance, got.distance,
							want.ascent, got.ascent, want.descent, got.descent,
							want.points, got.points, want.step, got.step);
				end
			end
		end
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import gto_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic         clk, arst_n;
	logic         s_tvalid, s_tready;
	logic [87:0]  s_tdata;    // latitude[30:0], longitude[62:31], altitude_cm[83:63]
	logic [1:0]   s_tuser;    // mode[1:0]
	logic         m_tvalid, m_tready;
	logic [167:0] m_tdata;    // distance[39:0], ascent[71:40], descent[103:72],
	                          // point_total[135:104], step_distance[166:136]
	logic [0:0]   m_tuser;    // recording[0]
	logic         psel, penable, pwrite, pready;
	logic [2:0]   paddr;
	logic [31:0]  pwdata, prdata;

	int mismatch_count, results_pending;
	int send_idle_pct, recv_idle_pct;
	int stall_cycles;
	logic            tb_rec;
	logic signed [30:0] near_lat;
	logic signed [31:0] near_lon;
	logic signed [20:0] near_alt;

	gps_track_odometer_top uut (.*);

	gto_checker odo_check (.*);

	// Free-running clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Randomly stall the result side
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	// Drop the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic reg_write(input logic reg_idx, input logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {reg_idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_request(input logic [1:0] mode, input logic [30:0] lat,
			input logic [31:0] lon, input logic [20:0] alt);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {4'b0, alt, lon, lat};
		if (mode == MODE_START)
			tb_rec = 1'b1;
		else if (mode == MODE_STOP)
			tb_rec = 1'b0;
		while (!s_tready)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic send_command(input logic [1:0] mode);
		send_request(mode, 31'($urandom), $urandom, 21'($urandom));
	endtask

	// Hold off until every result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (results_pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// Mostly plausible tracks with some noise and broken sessions
	task automatic random_track(input int n);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (!tb_rec) begin
				if (r < 75)
					send_command(MODE_START);
				else if (r < 85)
					send_command(MODE_STOP);
				else if (r < 90)
					send_command(KIND_IGNORE);
				else
					send_request(MODE_POINT, 31'($urandom), $urandom, 21'($urandom));
			end else if (r < 3) begin
				send_command(MODE_STOP);
			end else if (r < 5) begin
				send_command(MODE_START);
			end else if (r < 6) begin
				send_command(KIND_IGNORE);
			end else if (r < 20) begin
				near_lat = 31'($urandom);
				near_lon = $urandom;
				near_alt = 21'($urandom);
				send_request(MODE_POINT, near_lat, near_lon, near_alt);
			end else begin
				near_lat = near_lat + $signed(31'($urandom_range(4000000))) - 31'sd2000000;
				near_lon = near_lon + $signed(32'($urandom_range(4000000))) - 32'sd2000000;
				near_alt = near_alt + $signed(21'($urandom_range(4000))) - 21'sd2000;
				send_request(MODE_POINT, near_lat, near_lon, near_alt);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_POINT;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tb_rec = 1'b0;
		near_lat = 0;
		near_lon = 0;
		near_alt = 0;
		send_idle_pct = 37;
		recv_idle_pct = 66;
		stall_cycles = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: commands, first fix, extremes, poles, wrap and idle cases
		send_request(MODE_POINT, 31'sd100, 32'sd100, 21'sd10);
		send_command(MODE_STOP);
		send_command(MODE_START);
		send_request(MODE_POINT, 31'sd0, 32'sd0, 21'sd0);
		send_request(MODE_POINT, 31'sd900000000, 32'sd1800000000, 21'sd900000);
		send_request(MODE_POINT, -31'sd900000000, -32'sd1800000000, -21'sd50000);
		send_request(MODE_POINT, 31'h3FFFFFFF, 32'h7FFFFFFF, 21'h0FFFFF);
		send_request(MODE_POINT, 31'h40000000, 32'h80000000, 21'h100000);
		send_request(MODE_POINT, 31'sd0, 32'sd0, 21'sd50);
		send_request(MODE_POINT, 31'sd0, 32'sd1, 21'sd101);
		send_request(MODE_POINT, 31'sd0, 32'sd1, 21'sd50);
		send_request(MODE_POINT, 31'sd0, 32'sd1, 21'sd0);
		send_command(MODE_START);
		send_command(KIND_IGNORE);
		send_request(MODE_POINT, 31'sd10000000, 32'sd20000000, 21'sd500);
		send_command(MODE_STOP);
		send_request(MODE_POINT, 31'sd5, 32'sd5, 21'sd5);
		send_command(MODE_STOP);
		send_command(KIND_IGNORE);
		send_command(MODE_START);
		send_request(MODE_POINT, 31'sd1, 32'sd1, 21'sd1);
		send_request(MODE_POINT, 31'sd1, -32'sd1, 21'sd1);
		drain();

		reg_write(REG_CLIMB, 32'd0);
		reg_write(REG_RADIUS, 32'd6300000);
		random_track(250);
		drain();

		send_idle_pct = 66;
		recv_idle_pct = 37;
		reg_write(REG_CLIMB, 32'd1023);
		reg_write(REG_RADIUS, 32'd8388607);
		random_track(250);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		reg_write(REG_CLIMB, 32'd1000);
		reg_write(REG_RADIUS, 32'd6400000);
		random_track(250);
		drain();
		repeat (400) @(negedge clk);

		if (mismatch_count == 0 && results_pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
